[src/fraction_arith_reduce_top_defines.svh]
// ----------------------------------------------------------------------------
// Fraction arithmetic unit: assertion macros
// Shared checking macros for the fraction arithmetic top level.
// ----------------------------------------------------------------------------
`ifndef FRACTION_ARITH_REDUCE_TOP_DEFINES_SVH
`define FRACTION_ARITH_REDUCE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FAR_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FAR_CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/far_pkg.sv]
// ----------------------------------------------------------------------------
// Fraction arithmetic unit: package
// Widths, micro-op and condition codes, control/status structs and the
// microcode program shared by the sequencer and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package far_pkg;

  // operand and derived widths
  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int MW            = PROD_W + 1;          // sum of two products
  localparam int CNT_W         = $clog2(MW);          // divide bit count, shift count
  localparam int NUM_OUT_W     = 33;
  localparam int DEN_OUT_W     = 31;
  localparam int EXT_W         = (MW + 1 > NUM_OUT_W) ? MW + 1 : NUM_OUT_W;

  // operation codes
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  // datapath micro-ops
  typedef enum logic [3:0] {
    UOP_MUL1,
    UOP_MUL2,
    UOP_MUL3,
    UOP_COMB,
    UOP_GINIT,
    UOP_GSTRIP,
    UOP_GUEVEN,
    UOP_GLOOP,
    UOP_GFIN,
    UOP_DIV,
    UOP_OUT,
    UOP_OUT_ERR,
    UOP_OUT_ZERO
  } uop_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ERR,
    COND_RM_ZERO,
    COND_BOTH_EVEN,
    COND_U_EVEN,
    COND_V_NZ,
    COND_CNT_NZ
  } cond_t;

  typedef logic [3:0] pc_t;

  // program addresses
  localparam pc_t PC_MUL1   = 4'd0;
  localparam pc_t PC_MUL2   = 4'd1;
  localparam pc_t PC_MUL3   = 4'd2;
  localparam pc_t PC_COMB   = 4'd3;
  localparam pc_t PC_GINIT  = 4'd4;
  localparam pc_t PC_GSTRIP = 4'd5;
  localparam pc_t PC_GUEVEN = 4'd6;
  localparam pc_t PC_GLOOP  = 4'd7;
  localparam pc_t PC_GFIN   = 4'd8;
  localparam pc_t PC_DIV    = 4'd9;
  localparam pc_t PC_OUT    = 4'd10;
  localparam pc_t PC_ERR    = 4'd11;
  localparam pc_t PC_ZERO   = 4'd12;

  // one control word
  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic exec;
    uop_t uop;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic err;
    logic rm_zero;
    logic both_even;
    logic u_even;
    logic v_nz;
    logic cnt_nz;
  } stat_t;

  // microcode program
  function automatic uword_t ucode(pc_t addr);
    uword_t w;
    unique case (addr)
      PC_MUL1:   w = '{UOP_MUL1,     COND_ERR,       PC_ERR};
      PC_MUL2:   w = '{UOP_MUL2,     COND_NEVER,     PC_MUL2};
      PC_MUL3:   w = '{UOP_MUL3,     COND_NEVER,     PC_MUL3};
      PC_COMB:   w = '{UOP_COMB,     COND_NEVER,     PC_COMB};
      PC_GINIT:  w = '{UOP_GINIT,    COND_RM_ZERO,   PC_ZERO};
      PC_GSTRIP: w = '{UOP_GSTRIP,   COND_BOTH_EVEN, PC_GSTRIP};
      PC_GUEVEN: w = '{UOP_GUEVEN,   COND_U_EVEN,    PC_GUEVEN};
      PC_GLOOP:  w = '{UOP_GLOOP,    COND_V_NZ,      PC_GLOOP};
      PC_GFIN:   w = '{UOP_GFIN,     COND_NEVER,     PC_GFIN};
      PC_DIV:    w = '{UOP_DIV,      COND_CNT_NZ,    PC_DIV};
      PC_OUT:    w = '{UOP_OUT,      COND_NEVER,     PC_OUT};
      PC_ERR:    w = '{UOP_OUT_ERR,  COND_NEVER,     PC_ERR};
      PC_ZERO:   w = '{UOP_OUT_ZERO, COND_NEVER,     PC_ZERO};
      default:   w = '{UOP_OUT_ERR,  COND_NEVER,     PC_ERR};
    endcase
    return w;
  endfunction

  // micro-ops that deliver the result and end the program
  function automatic logic is_final(uop_t op);
    return (op == UOP_OUT) || (op == UOP_OUT_ERR) || (op == UOP_OUT_ZERO);
  endfunction

endpackage

[src/far_useq.sv]
// ----------------------------------------------------------------------------
// Fraction arithmetic unit: microcode sequencer
// Step counter over the program ROM with conditional jumps on datapath status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module far_useq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  far_pkg::stat_t  stat,
  output logic            busy,
  output far_pkg::ctrl_t  ctrl
);

  far_pkg::pc_t    pc;
  far_pkg::uword_t word;
  logic            take;

  assign word = far_pkg::ucode(pc);

  // jump condition select
  always_comb begin
    unique case (word.cond)
      far_pkg::COND_NEVER:     take = 1'b0;
      far_pkg::COND_ERR:       take = stat.err;
      far_pkg::COND_RM_ZERO:   take = stat.rm_zero;
      far_pkg::COND_BOTH_EVEN: take = stat.both_even;
      far_pkg::COND_U_EVEN:    take = stat.u_even;
      far_pkg::COND_V_NZ:      take = stat.v_nz;
      far_pkg::COND_CNT_NZ:    take = stat.cnt_nz;
      default:                 take = 1'b0;
    endcase
  end

  assign ctrl.exec = busy;
  assign ctrl.uop  = word.uop;

  // step counter and run flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= far_pkg::PC_MUL1;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        pc   <= far_pkg::PC_MUL1;
      end
    end else if (far_pkg::is_final(word.uop)) begin
      busy <= 1'b0;
    end else if (take) begin
      pc <= word.target;
    end else begin
      pc <= pc + far_pkg::pc_t'(1);
    end
  end

endmodule

[src/fraction_arith_reduce_top.sv]
// ----------------------------------------------------------------------------
// Fraction arithmetic unit: add, subtract, multiply or divide, reduced by GCD
// The program ends early on an error or on a zero result; otherwise the run
// also takes one step per shift or subtract of the binary GCD and then the
// restoring divide. One item at a time: no new start is taken while busy;
// busy falls as done pulses, so a new start is taken then.
// Results cannot be held off. Synchronous reset clears the sequencer and the
// strobe; data regs are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fraction_arith_reduce_top_defines.svh"

module fraction_arith_reduce_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            mode,
  input  logic signed [far_pkg::OPERAND_WIDTH-1:0] num_a,
  input  logic signed [far_pkg::OPERAND_WIDTH-1:0] den_a,
  input  logic signed [far_pkg::OPERAND_WIDTH-1:0] num_b,
  input  logic signed [far_pkg::OPERAND_WIDTH-1:0] den_b,
  output logic                                  done,
  output logic signed [far_pkg::NUM_OUT_W-1:0]  res_num,
  output logic [far_pkg::DEN_OUT_W-1:0]         res_den,
  output logic                                  is_whole,
  output logic                                  error
);

  localparam int W = far_pkg::OPERAND_WIDTH;

  // magnitude of a two's complement operand; the most negative maps to 2^(W-1)
  function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  far_pkg::ctrl_t ctrl;
  far_pkg::stat_t stat;
  logic           accept;

  // operand registers
  logic [1:0]   mode_r;
  logic         na_n, da_n, nb_n, db_n;
  logic [W-1:0] na_m, da_m, nb_m, db_m;

  // products, result terms, GCD and divide registers
  logic [far_pkg::PROD_W-1:0] t1, t2;
  logic [far_pkg::MW-1:0]     rm, dm, u, v, g, qn, qd, remn, remd;
  logic                       rn, dn;
  logic [far_pkg::CNT_W-1:0]  k, cnt;

  // shared multiplier
  logic [W-1:0]               mul_a, mul_b;
  logic [far_pkg::PROD_W-1:0] mul_p;

  // add/subtract of cross products
  logic [far_pkg::MW-1:0] am, bm, sm_sum, sm_ab, sm_ba, comb_m;
  logic                   an, bn, comb_n, comb_dn;

  // GCD step
  logic [far_pkg::MW-1:0] u_minus_v, v_minus_u;

  // divide lanes
  logic [far_pkg::MW:0]   shn, shd, gx;
  logic [far_pkg::MW:0]   subn, subd;
  logic                   gen, ged;

  // result formatting
  logic [far_pkg::EXT_W-1:0] qn_ext, num_ext, den_ext;

  assign accept = start && !busy;

  far_useq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // status back to the sequencer
  assign stat.err       = (da_m == '0) || (db_m == '0) ||
                          ((mode_r == far_pkg::MODE_DIV) && (nb_m == '0));
  assign stat.rm_zero   = (rm == '0);
  assign stat.both_even = !u[0] && !v[0];
  assign stat.u_even    = !u[0];
  assign stat.v_nz      = (v != '0);
  assign stat.cnt_nz    = (cnt != '0);

  // multiplier operand select
  always_comb begin
    if (ctrl.uop == far_pkg::UOP_MUL2) begin
      mul_a = nb_m;
      mul_b = da_m;
    end else if (ctrl.uop == far_pkg::UOP_MUL3) begin
      mul_a = da_m;
      mul_b = (mode_r == far_pkg::MODE_DIV) ? nb_m : db_m;
    end else begin
      mul_a = na_m;
      mul_b = (mode_r == far_pkg::MODE_MUL) ? nb_m : db_m;
    end
  end

  assign mul_p = far_pkg::PROD_W'(mul_a) * far_pkg::PROD_W'(mul_b);

  // sign-magnitude combine of the two terms
  assign am     = far_pkg::MW'(t1);
  assign bm     = far_pkg::MW'(t2);
  assign an     = na_n ^ db_n;
  assign bn     = nb_n ^ da_n ^ (mode_r == far_pkg::MODE_SUB);
  assign sm_sum = am + bm;
  assign sm_ab  = am - bm;
  assign sm_ba  = bm - am;

  always_comb begin
    unique case (mode_r)
      far_pkg::MODE_ADD, far_pkg::MODE_SUB: begin
        if (an == bn) begin
          comb_m = sm_sum;
          comb_n = an;
        end else if (am >= bm) begin
          comb_m = sm_ab;
          comb_n = an;
        end else begin
          comb_m = sm_ba;
          comb_n = bn;
        end
      end
      far_pkg::MODE_MUL: begin
        comb_m = am;
        comb_n = na_n ^ nb_n;
      end
      default: begin
        comb_m = am;
        comb_n = na_n ^ db_n;
      end
    endcase
  end

  assign comb_dn = da_n ^ ((mode_r == far_pkg::MODE_DIV) ? nb_n : db_n);

  assign u_minus_v = u - v;
  assign v_minus_u = v - u;

  // restoring divide, one quotient bit per lane per step
  assign gx   = {1'b0, g};
  assign shn  = {remn, qn[far_pkg::MW-1]};
  assign shd  = {remd, qd[far_pkg::MW-1]};
  assign gen  = shn >= gx;
  assign ged  = shd >= gx;
  assign subn = shn - gx;
  assign subd = shd - gx;

  // signed numerator, wrapped to the output width
  assign qn_ext  = far_pkg::EXT_W'(qn);
  assign num_ext = rn ? (far_pkg::EXT_W'(0) - qn_ext) : qn_ext;
  assign den_ext = far_pkg::EXT_W'(qd);

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode;
      na_n   <= num_a[W-1];
      da_n   <= den_a[W-1];
      nb_n   <= num_b[W-1];
      db_n   <= den_b[W-1];
      na_m   <= mag_of(num_a);
      da_m   <= mag_of(den_a);
      nb_m   <= mag_of(num_b);
      db_m   <= mag_of(den_b);
    end
    if (ctrl.exec) begin
      unique case (ctrl.uop)
        far_pkg::UOP_MUL1: t1 <= mul_p;
        far_pkg::UOP_MUL2: t2 <= mul_p;
        far_pkg::UOP_MUL3: dm <= far_pkg::MW'(mul_p);
        far_pkg::UOP_COMB: begin
          rm <= comb_m;
          rn <= comb_n;
          dn <= comb_dn;
        end
        far_pkg::UOP_GINIT: begin
          u  <= rm;
          v  <= dm;
          k  <= '0;
          rn <= rn ^ dn;
        end
        far_pkg::UOP_GSTRIP: begin
          if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + far_pkg::CNT_W'(1);
          end
        end
        far_pkg::UOP_GUEVEN: begin
          if (!u[0]) begin
            u <= u >> 1;
          end
        end
        far_pkg::UOP_GLOOP: begin
          if (!v[0]) begin
            v <= v >> 1;
          end else if (u > v) begin
            u <= v;
            v <= u_minus_v;
          end else begin
            v <= v_minus_u;
          end
        end
        far_pkg::UOP_GFIN: begin
          g    <= u << k;
          remn <= '0;
          remd <= '0;
          qn   <= rm;
          qd   <= dm;
          cnt  <= far_pkg::CNT_W'(far_pkg::MW - 1);
        end
        far_pkg::UOP_DIV: begin
          remn <= gen ? subn[far_pkg::MW-1:0] : shn[far_pkg::MW-1:0];
          remd <= ged ? subd[far_pkg::MW-1:0] : shd[far_pkg::MW-1:0];
          qn   <= {qn[far_pkg::MW-2:0], gen};
          qd   <= {qd[far_pkg::MW-2:0], ged};
          cnt  <= cnt - far_pkg::CNT_W'(1);
        end
        far_pkg::UOP_OUT: begin
          res_num  <= num_ext[far_pkg::NUM_OUT_W-1:0];
          res_den  <= den_ext[far_pkg::DEN_OUT_W-1:0];
          is_whole <= (qd == far_pkg::MW'(1));
          error    <= 1'b0;
        end
        far_pkg::UOP_OUT_ERR: begin
          res_num  <= '0;
          res_den  <= far_pkg::DEN_OUT_W'(1);
          is_whole <= 1'b0;
          error    <= 1'b1;
        end
        far_pkg::UOP_OUT_ZERO: begin
          res_num  <= '0;
          res_den  <= far_pkg::DEN_OUT_W'(1);
          is_whole <= 1'b1;
          error    <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // result strobe, one cycle per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.exec && far_pkg::is_final(ctrl.uop);
    end
  end

  // checks
  `FAR_CHK_NOW(a_done_idle, done, !busy, "result strobe while still running")
  `FAR_CHK_NXT(a_start_runs, start && !busy, busy && !done, "start beat not taken")
  `FAR_CHK_NOW(a_whole_den, done && is_whole, res_den == far_pkg::DEN_OUT_W'(1), "den not one")
  `FAR_CHK_NOW(a_err_zero, done && error, res_num == '0 && !is_whole, "error result not cleared")

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Testbench for fraction_arith_reduce_top
// Sends pairs of signed fractions with an operation through the start/busy
// handshake, first from a short table of corner cases and then at random,
// and checks every done beat against a reduced fraction, taken from the table
// or worked out here in sign and magnitude with a Euclidean GCD.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int OW = far_pkg::OPERAND_WIDTH;
  localparam int RANDOM_ITEMS = 750;
  localparam int TAIL_CYCLES = 160;
  localparam int REPORT_LIMIT = 10;

  // operand shapes for the random part
  localparam int unsigned STYLE_FULL   = 0;
  localparam int unsigned STYLE_SMALL  = 1;
  localparam int unsigned STYLE_FACTOR = 2;
  localparam int unsigned STYLE_CORNER = 3;

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [OW-1:0] num_a;
    logic signed [OW-1:0] den_a;
    logic signed [OW-1:0] num_b;
    logic signed [OW-1:0] den_b;
  } frac_item_t;

  typedef struct packed {
    logic signed [far_pkg::NUM_OUT_W-1:0] num;
    logic [far_pkg::DEN_OUT_W-1:0]        den;
    logic                                 whole;
    logic                                 err;
  } frac_res_t;

  // one row of stimulus; typed rows carry their answer
  typedef struct packed {
    frac_item_t it;
    logic       known;
    frac_res_t  want;
  } frac_row_t;

  typedef struct packed {
    frac_res_t   want;
    int unsigned tag;
  } frac_exp_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic [1:0]                           mode = far_pkg::MODE_ADD;
  logic signed [OW-1:0]                 num_a = '0;
  logic signed [OW-1:0]                 den_a = '0;
  logic signed [OW-1:0]                 num_b = '0;
  logic signed [OW-1:0]                 den_b = '0;
  logic                                 done;
  logic signed [far_pkg::NUM_OUT_W-1:0] res_num;
  logic [far_pkg::DEN_OUT_W-1:0]        res_den;
  logic                                 is_whole;
  logic                                 error;

  frac_row_t   stim_rows[$];
  frac_exp_t   expected_fracs[$];
  int unsigned mismatches = 0;
  int unsigned stray_beats = 0;
  int unsigned checked = 0;
  int unsigned sent_by_mode[4] = '{0, 0, 0, 0};
  int unsigned sent_errors = 0;
  int unsigned sent_wholes = 0;

  fraction_arith_reduce_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .num_a    (num_a),
    .den_a    (den_a),
    .num_b    (num_b),
    .den_b    (den_b),
    .done     (done),
    .res_num  (res_num),
    .res_den  (res_den),
    .is_whole (is_whole),
    .error    (error)
  );

  always #1 clk = ~clk;

  // split a two's complement operand into sign and magnitude
  function automatic void to_sign_mag(input logic signed [OW-1:0] v, output bit neg,
                                      output longint unsigned mag);
    longint sv;
    sv = v;
    neg = (sv < 0);
    if (neg) mag = -sv;
    else mag = sv;
  endfunction

  // cross products, sign to the numerator, reduce by the GCD
  function automatic frac_res_t reduce_fraction(frac_item_t it);
    frac_res_t r;
    bit sna, sda, snb, sdb, s1, s2, rn, dn;
    longint unsigned mna, mda, mnb, mdb, p1, p2, rm, dm, a, b, t, full;
    to_sign_mag(it.num_a, sna, mna);
    to_sign_mag(it.den_a, sda, mda);
    to_sign_mag(it.num_b, snb, mnb);
    to_sign_mag(it.den_b, sdb, mdb);
    r = '{num: '0, den: 1, whole: 1'b0, err: 1'b1};
    if (mda == 0 || mdb == 0 || (it.mode == far_pkg::MODE_DIV && mnb == 0)) return r;
    case (it.mode)
      far_pkg::MODE_ADD, far_pkg::MODE_SUB: begin
        s1 = sna ^ sdb;
        p1 = mna * mdb;
        s2 = snb ^ sda;
        if (it.mode == far_pkg::MODE_SUB) s2 = ~s2;
        p2 = mnb * mda;
        if (s1 == s2) begin
          rn = s1;
          rm = p1 + p2;
        end else if (p1 >= p2) begin
          rn = s1;
          rm = p1 - p2;
        end else begin
          rn = s2;
          rm = p2 - p1;
        end
        dn = sda ^ sdb;
        dm = mda * mdb;
      end
      far_pkg::MODE_MUL: begin
        rn = sna ^ snb;
        rm = mna * mnb;
        dn = sda ^ sdb;
        dm = mda * mdb;
      end
      default: begin
        rn = sna ^ sdb;
        rm = mna * mdb;
        dn = sda ^ snb;
        dm = mda * mnb;
      end
    endcase
    r.err = 1'b0;
    if (rm == 0) begin
      r.whole = 1'b1;
      return r;
    end
    a = rm;
    b = dm;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    rm = rm / a;
    dm = dm / a;
    full = (rn ^ dn) ? (64'd0 - rm) : rm;
    r.num = full[far_pkg::NUM_OUT_W-1:0];
    r.den = dm[far_pkg::DEN_OUT_W-1:0];
    r.whole = (dm == 1);
    return r;
  endfunction

  task automatic add_row(logic [1:0] m, int na, int da, int nb, int db, bit known = 1'b0,
                         longint n = 0, longint d = 1, bit w = 1'b0, bit e = 1'b0);
    frac_row_t r;
    r.it = '{mode: m, num_a: na[OW-1:0], den_a: da[OW-1:0],
             num_b: nb[OW-1:0], den_b: db[OW-1:0]};
    r.known = known;
    r.want = '{num: n[far_pkg::NUM_OUT_W-1:0], den: d[far_pkg::DEN_OUT_W-1:0],
               whole: w, err: e};
    stim_rows.push_back(r);
  endtask

  function automatic logic [OW-1:0] pick_operand(int unsigned style, int f);
    logic [31:0] w;
    int s;
    case (style)
      STYLE_FULL: w = $urandom;
      STYLE_SMALL: begin
        s = int'($urandom_range(0, 80)) - 40;
        w = s;
      end
      STYLE_FACTOR: begin
        s = (int'($urandom_range(0, 80)) - 40) * f;
        w = s;
      end
      default: begin
        case ($urandom_range(0, 7))
          0: s = -(2 ** (OW - 1));
          1: s = 1 - 2 ** (OW - 1);
          2: s = -1;
          3: s = 0;
          4: s = 1;
          5: s = 2;
          6: s = 2 ** (OW - 1) - 1;
          default: s = 2 ** (OW - 1) - 2;
        endcase
        w = s;
      end
    endcase
    return w[OW-1:0];
  endfunction

  // random operands; a share of them built from common factors so the GCD has work
  function automatic frac_row_t random_fraction();
    frac_row_t r;
    int unsigned pick, style;
    logic [31:0] w;
    int f;
    int factors[8] = '{2, 3, 4, 6, 12, 60, 120, 720};
    pick = $urandom_range(0, 19);
    if (pick < 8) style = STYLE_FULL;
    else if (pick < 14) style = STYLE_SMALL;
    else if (pick < 17) style = STYLE_FACTOR;
    else style = STYLE_CORNER;
    f = factors[$urandom_range(0, 7)];
    w = $urandom_range(0, 3);
    r.it.mode = w[1:0];
    r.it.num_a = pick_operand(style, f);
    r.it.den_a = pick_operand(style, f);
    r.it.num_b = pick_operand(style, f);
    r.it.den_b = pick_operand(style, f);
    // a few forced error cases on top of the natural ones
    case ($urandom_range(0, 39))
      0: r.it.den_a = '0;
      1: r.it.den_b = '0;
      2: begin
        r.it.mode = far_pkg::MODE_DIV;
        r.it.num_b = '0;
      end
      default: ;
    endcase
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // result monitor: one beat per done strobe, no back-pressure
  always @(posedge clk) begin
    frac_exp_t head;
    if (!rst && done) begin
      if (expected_fracs.size() == 0) begin
        stray_beats++;
        if (mismatches + stray_beats <= REPORT_LIMIT)
          $display("unexpected result beat: %0d/%0d whole=%0b err=%0b",
                   res_num, res_den, is_whole, error);
      end else begin
        head = expected_fracs.pop_front();
        checked++;
        if (res_num !== head.want.num || res_den !== head.want.den ||
            is_whole !== head.want.whole || error !== head.want.err) begin
          mismatches++;
          if (mismatches + stray_beats <= REPORT_LIMIT)
            $display("item %0d: expected %0d/%0d whole=%0b err=%0b, got %0d/%0d whole=%0b err=%0b",
                     head.tag, head.want.num, head.want.den, head.want.whole, head.want.err,
                     res_num, res_den, is_whole, error);
        end
      end
    end
  end

  // stimulus: directed table, then random items sent in bursts
  initial begin
    frac_row_t   row;
    frac_exp_t   e;
    frac_row_t   junk;
    int unsigned idx;
    int unsigned burst_left;
    int unsigned gap;
    int unsigned failures;

    // zero denominators and division by a zero fraction
    add_row(far_pkg::MODE_ADD, 1, 0, 1, 2, 1'b1, 0, 1, 1'b0, 1'b1);
    add_row(far_pkg::MODE_SUB, 3, 4, 5, 0, 1'b1, 0, 1, 1'b0, 1'b1);
    add_row(far_pkg::MODE_DIV, 7, 9, 0, 5, 1'b1, 0, 1, 1'b0, 1'b1);
    add_row(far_pkg::MODE_DIV, 0, 0, 0, 0, 1'b1, 0, 1, 1'b0, 1'b1);
    // zero results come out as 0/1
    add_row(far_pkg::MODE_MUL, 0, 5, 3, 7, 1'b1, 0, 1, 1'b1, 1'b0);
    add_row(far_pkg::MODE_MUL, 5, 7, 0, 3, 1'b1, 0, 1, 1'b1, 1'b0);
    add_row(far_pkg::MODE_DIV, 0, 5, 3, 4, 1'b1, 0, 1, 1'b1, 1'b0);
    add_row(far_pkg::MODE_SUB, 3, 4, 3, 4, 1'b1, 0, 1, 1'b1, 1'b0);
    add_row(far_pkg::MODE_ADD, 1, -2, 1, 2, 1'b1, 0, 1, 1'b1, 1'b0);
    // operand extremes
    add_row(far_pkg::MODE_ADD, 32767, 1, 32767, 1, 1'b1, 65534, 1, 1'b1, 1'b0);
    add_row(far_pkg::MODE_SUB, -32768, 1, 32767, 1, 1'b1, -65535, 1, 1'b1, 1'b0);
    add_row(far_pkg::MODE_MUL, -32768, 1, -32768, 1, 1'b1, 1073741824, 1, 1'b1, 1'b0);
    add_row(far_pkg::MODE_MUL, 1, -32768, 1, -32768, 1'b1, 1, 1073741824, 1'b0, 1'b0);
    add_row(far_pkg::MODE_ADD, -32768, -32768, -32768, -32768, 1'b1, 2, 1, 1'b1, 1'b0);
    add_row(far_pkg::MODE_DIV, 1, 1, 1, -1, 1'b1, -1, 1, 1'b1, 1'b0);
    // ordinary reductions and mixed-sign extremes
    add_row(far_pkg::MODE_ADD, 1, 2, 1, 3);
    add_row(far_pkg::MODE_SUB, 1, 6, 1, 3);
    add_row(far_pkg::MODE_MUL, 2, 3, 3, 4);
    add_row(far_pkg::MODE_DIV, 6, 35, 10, 21);
    add_row(far_pkg::MODE_ADD, -32768, 32767, -32768, -32767);
    add_row(far_pkg::MODE_DIV, -32768, -32768, 32767, 32767);
    add_row(far_pkg::MODE_SUB, 32767, -32768, -32768, 32767);
    add_row(far_pkg::MODE_DIV, 32767, -1, -32768, 1);
    repeat (RANDOM_ITEMS) stim_rows.push_back(random_fraction());

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idx = 0;
    burst_left = $urandom_range(1, 16);
    while (idx < stim_rows.size()) begin
      row = stim_rows[idx];
      start <= 1'b1;
      mode  <= row.it.mode;
      num_a <= row.it.num_a;
      den_a <= row.it.den_a;
      num_b <= row.it.num_b;
      den_b <= row.it.den_b;
      @(posedge clk);
      while (busy) @(posedge clk);
      // beat taken at this edge
      e.want = row.known ? row.want : reduce_fraction(row.it);
      e.tag = idx;
      expected_fracs.push_back(e);
      sent_by_mode[row.it.mode]++;
      if (e.want.err) sent_errors++;
      if (e.want.whole) sent_wholes++;
      idx++;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // long bursts now and then give stretches with no idling
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(0, 12);
        case ($urandom_range(0, 3))
          0: gap = $urandom_range(1, 3);
          1: gap = $urandom_range(4, 20);
          2: gap = $urandom_range(21, 160);
          default: gap = 0;
        endcase
        if (gap > 0 || idx == stim_rows.size()) begin
          // fields wander while start is low
          junk = random_fraction();
          start <= 1'b0;
          mode  <= junk.it.mode;
          num_a <= junk.it.num_a;
          den_a <= junk.it.den_a;
          num_b <= junk.it.num_b;
          den_b <= junk.it.den_b;
          repeat (gap) @(posedge clk);
        end
      end
    end
    if (start) start <= 1'b0;

    while (expected_fracs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    failures = mismatches + stray_beats + expected_fracs.size();
    $display("%0d fractions sent (add %0d, sub %0d, mul %0d, div %0d), %0d error cases, %0d whole",
             idx, sent_by_mode[far_pkg::MODE_ADD], sent_by_mode[far_pkg::MODE_SUB],
             sent_by_mode[far_pkg::MODE_MUL], sent_by_mode[far_pkg::MODE_DIV],
             sent_errors, sent_wholes);
    $display("%0d results checked, %0d wrong, %0d unexpected", checked, mismatches, stray_beats);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
